### rtl/heightmap_quad_vertex_normals_unit_macros.svh
// assertion macros for the heightmap quad vertex normals unit
// expects clk and rst_n in the scope of each use
`ifndef HEIGHTMAP_QUAD_VERTEX_NORMALS_UNIT_MACROS_SVH
`define HEIGHTMAP_QUAD_VERTEX_NORMALS_UNIT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define HQVN_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hqvn check failed");
// next-cycle implication
`define HQVN_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hqvn check failed");
`else
`define HQVN_SAME(label, ante, cons)
`define HQVN_NEXT(label, ante, cons)
`endif
`endif

### rtl/hqvn_pkg.sv
// shared constants, types and lookup functions of the heightmap vertex unit
// no dependencies
package hqvn_pkg;

  localparam int CHUNK_WIDTH = 64;

  localparam int MAG_W   = 16;
  localparam int MAG2_W  = 32;
  localparam int SUM_W   = 33;
  localparam int REM_W   = SUM_W + 1;
  localparam int QUO_W   = 31;

  localparam int DIV_STEPS   = QUO_W;
  localparam int DIV_PER_STG = 2;
  localparam int DIV_STAGES  = (DIV_STEPS + DIV_PER_STG - 1) / DIV_PER_STG;

  localparam int RAD_W      = QUO_W + 1;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int SQ_REM_W   = ROOT_W + 3;
  localparam int SQ_STEPS   = ROOT_W;
  localparam int SQ_PER_STG = 2;
  localparam int SQ_STAGES  = (SQ_STEPS + SQ_PER_STG - 1) / SQ_PER_STG;

  localparam int LANE_STAGES = DIV_STAGES + SQ_STAGES;
  localparam int NRM_W       = 15;

  localparam logic [MAG2_W-1:0] ONE_SQ    = 32'd65536;
  localparam logic [1:0]        LAST_BEAT = 2'd3;

  localparam int NUM_LIMITS = 10;
  localparam logic [7:0] BAND_LIMIT [NUM_LIMITS] = '{
    8'd8, 8'd16, 8'd20, 8'd32, 8'd36, 8'd48, 8'd56, 8'd72, 8'd88, 8'd96
  };

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // per-cell data that rides along the pipeline
  typedef struct packed {
    logic [6:0]       cell_x;
    logic [6:0]       cell_z;
    logic [13:0]      vbase;
    logic [3:0][15:0] height;
    logic [3:0]       band;
    logic             neg_xa;
    logic             neg_za;
    logic             neg_xb;
    logic             neg_zb;
  } side_t;

  // number of thresholds at or below the integer part of the height
  function automatic logic [3:0] band_of(logic [7:0] hi);
    logic [3:0] cnt;
    cnt = '0;
    for (int i = 0; i < NUM_LIMITS; i++) begin
      if (hi >= BAND_LIMIT[i]) cnt = cnt + 4'd1;
    end
    return cnt;
  endfunction

  function automatic rgb_t colour_of(logic [3:0] band);
    rgb_t c;
    unique case (band)
      4'd0:    c = '{red: 8'd0,   green: 8'd51,  blue: 8'd204};
      4'd1:    c = '{red: 8'd0,   green: 8'd128, blue: 8'd255};
      4'd2:    c = '{red: 8'd255, green: 8'd255, blue: 8'd128};
      4'd3:    c = '{red: 8'd51,  green: 8'd204, blue: 8'd26};
      4'd4:    c = '{red: 8'd51,  green: 8'd153, blue: 8'd26};
      4'd5:    c = '{red: 8'd51,  green: 8'd128, blue: 8'd26};
      4'd6:    c = '{red: 8'd77,  green: 8'd77,  blue: 8'd26};
      4'd7:    c = '{red: 8'd102, green: 8'd51,  blue: 8'd26};
      4'd8:    c = '{red: 8'd153, green: 8'd102, blue: 8'd77};
      4'd9:    c = '{red: 8'd255, green: 8'd204, blue: 8'd179};
      default: c = '{red: 8'd255, green: 8'd255, blue: 8'd255};
    endcase
    return c;
  endfunction

endpackage

### rtl/hqvn_norm_lane.sv
// one normal component lane: round(mag * 16384 / sqrt(sum))
// pipelined restoring divide then digit-by-digit square root; uses hqvn_pkg
module hqvn_norm_lane (
  input  logic                          clk,
  input  logic                          en,
  input  logic [hqvn_pkg::MAG2_W-1:0]   mag2_i,
  input  logic [hqvn_pkg::SUM_W-1:0]    sum_i,
  output logic [hqvn_pkg::NRM_W-1:0]    mag_o
);
  import hqvn_pkg::*;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_t;

  typedef struct packed {
    logic [RAD_W-1:0]    rad;
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
  } sq_t;

  // one quotient bit of mag2 * 2^30 / sum
  function automatic div_t div_step(div_t d, logic [SUM_W-1:0] s);
    div_t             o;
    logic [REM_W-1:0] diff;
    logic             take;
    take  = d.rem >= REM_W'(s);
    diff  = d.rem - REM_W'(s);
    o.quo = {d.quo[QUO_W-2:0], take};
    o.rem = take ? {diff[REM_W-2:0], 1'b0} : {d.rem[REM_W-2:0], 1'b0};
    return o;
  endfunction

  // one root bit
  function automatic sq_t sq_step(sq_t d);
    sq_t                 o;
    logic [SQ_REM_W-1:0] cur;
    logic [SQ_REM_W-1:0] trial;
    logic                take;
    cur    = {d.rem[SQ_REM_W-3:0], d.rad[RAD_W-1 -: 2]};
    trial  = SQ_REM_W'({d.root, 2'b01});
    take   = cur >= trial;
    o.rad  = {d.rad[RAD_W-3:0], 2'b00};
    o.rem  = take ? (cur - trial) : cur;
    o.root = {d.root[ROOT_W-2:0], take};
    return o;
  endfunction

  div_t             div_r   [DIV_STAGES];
  div_t             div_nxt [DIV_STAGES];
  logic [SUM_W-1:0] sum_r   [DIV_STAGES-1];
  sq_t              sq_r    [SQ_STAGES];
  sq_t              sq_nxt  [SQ_STAGES];
  logic [ROOT_W-1:0] round_sum;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    logic [SUM_W-1:0] s_cur;
    div_t             d_in;
    if (g == 0) begin : g_first
      assign s_cur = sum_i;
      assign d_in  = '{rem: REM_W'(mag2_i), quo: '0};
    end else begin : g_rest
      assign s_cur = sum_r[g-1];
      assign d_in  = div_r[g-1];
    end

    always_comb begin
      div_nxt[g] = d_in;
      for (int j = 0; j < DIV_PER_STG; j++) begin
        if (g * DIV_PER_STG + j < DIV_STEPS) div_nxt[g] = div_step(div_nxt[g], s_cur);
      end
    end

    always_ff @(posedge clk) begin
      if (en) div_r[g] <= div_nxt[g];
    end

    if (g < DIV_STAGES - 1) begin : g_sum
      always_ff @(posedge clk) begin
        if (en) sum_r[g] <= s_cur;
      end
    end
  end

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sq
    sq_t q_in;
    if (g == 0) begin : g_first
      assign q_in = '{rad: RAD_W'(div_r[DIV_STAGES-1].quo), rem: '0, root: '0};
    end else begin : g_rest
      assign q_in = sq_r[g-1];
    end

    always_comb begin
      sq_nxt[g] = q_in;
      for (int j = 0; j < SQ_PER_STG; j++) begin
        if (g * SQ_PER_STG + j < SQ_STEPS) sq_nxt[g] = sq_step(sq_nxt[g]);
      end
    end

    always_ff @(posedge clk) begin
      if (en) sq_r[g] <= sq_nxt[g];
    end
  end

  // largest odd value under the root gives the rounded magnitude
  assign round_sum = sq_r[SQ_STAGES-1].root + ROOT_W'(1);
  assign mag_o     = round_sum[NRM_W:1];

endmodule

### rtl/heightmap_quad_vertex_normals_unit.sv
// heightmap quad vertex normals unit: cell in, four mesh vertices out
// uses hqvn_pkg, hqvn_norm_lane and the assertion macro header
//
//  channel  | ports                        | beat
//  ---------+------------------------------+--------------------------------------
//  input    | in_valid / in_stall / in_*   | one grid cell: coords, four heights
//  output   | out_valid / out_stall / out_*| one vertex: number, position, colour,
//           |                              | normal, last flag
//
// from its input beat to its first vertex beat a cell passes three front stages
// (differences and band, squares, sums), 24 lane stages (16 divide stages of up to two
// quotient bits, 8 root stages of two root bits) and the output register
// each cell gives four output beats from one output register, so the single output
// port sets the sustained cell rate
// reset clears the stage valid bits, the output valid and the beat counter only
// out_stall freezes the whole pipeline, bubbles included, only while the last stage
// holds a cell and the output register is still busy; in_stall follows that freeze
`include "heightmap_quad_vertex_normals_unit_macros.svh"

module heightmap_quad_vertex_normals_unit (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [6:0]         in_cell_x,
  input  logic [6:0]         in_cell_z,
  input  logic [15:0]        in_height_here,
  input  logic [15:0]        in_height_next_x,
  input  logic [15:0]        in_height_next_z,
  input  logic [15:0]        in_height_diagonal,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_vertex_number,
  output logic [7:0]         out_pos_x,
  output logic [7:0]         out_pos_z,
  output logic [15:0]        out_pos_height,
  output logic [7:0]         out_colour_red,
  output logic [7:0]         out_colour_green,
  output logic [7:0]         out_colour_blue,
  output logic signed [15:0] out_normal_x,
  output logic [14:0]        out_normal_y,
  output logic signed [15:0] out_normal_z,
  output logic               out_last_vertex
);
  import hqvn_pkg::*;

  localparam int NSTG = 3 + LANE_STAGES;

  // magnitude of a 17-bit two's complement difference
  function automatic logic [MAG_W-1:0] mag_of(logic [16:0] d);
    logic [16:0] n;
    n = d[16] ? (~d + 17'd1) : d;
    return n[MAG_W-1:0];
  endfunction

  // the normal component points against a rising slope
  function automatic logic [15:0] signed_nrm(logic neg, logic [NRM_W-1:0] m);
    logic [15:0] w;
    w = {1'b0, m};
    return neg ? (~w + 16'd1) : w;
  endfunction

  // pipeline control
  logic            adv;
  logic            beat_take;
  logic            hold_free;
  logic            is_last;
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;

  // front stage logic
  logic [16:0] dxa, dza, dxb, dzb;
  logic [15:0] cell_lin;
  side_t       side_in;

  // stage registers
  side_t                   side_r [NSTG];
  logic [3:0][MAG_W-1:0]   mag_r;
  logic [3:0][MAG2_W-1:0]  sq_r;
  logic [3:0][MAG2_W-1:0]  sq2_r;
  logic [SUM_W-1:0]        sum_a_r;
  logic [SUM_W-1:0]        sum_b_r;

  // lane results: x, y, z of the first triangle then of the second
  logic [NRM_W-1:0] lane_mag [6];

  // output register
  logic             hold_vld_r, hold_vld_nxt;
  logic [1:0]       hold_k_r, hold_k_nxt;
  side_t            hold_side_r;
  logic [15:0]      hold_na_x_r, hold_na_z_r, hold_nb_x_r, hold_nb_z_r;
  logic [NRM_W-1:0] hold_na_y_r, hold_nb_y_r;
  rgb_t             rgb;

  // handshake and advance
  assign beat_take = hold_vld_r && !out_stall;
  assign is_last   = (hold_k_r == LAST_BEAT);
  assign hold_free = !hold_vld_r || (beat_take && is_last);
  assign adv       = !vld_r[NSTG-1] || hold_free;
  assign in_stall  = !adv;

  // slopes of both triangles, band and vertex base
  always_comb begin
    dxa      = {1'b0, in_height_next_x}   - {1'b0, in_height_here};
    dza      = {1'b0, in_height_next_z}   - {1'b0, in_height_here};
    dxb      = {1'b0, in_height_diagonal} - {1'b0, in_height_next_z};
    dzb      = {1'b0, in_height_diagonal} - {1'b0, in_height_next_x};
    cell_lin = 16'(in_cell_x) * 16'(CHUNK_WIDTH) + 16'(in_cell_z);

    side_in.cell_x    = in_cell_x;
    side_in.cell_z    = in_cell_z;
    side_in.vbase     = cell_lin[13:0];
    side_in.height[0] = in_height_here;
    side_in.height[1] = in_height_next_x;
    side_in.height[2] = in_height_next_z;
    side_in.height[3] = in_height_diagonal;
    side_in.band      = band_of(in_height_here[15:8]);
    side_in.neg_xa    = !dxa[16] && (dxa != 17'd0);
    side_in.neg_za    = !dza[16] && (dza != 17'd0);
    side_in.neg_xb    = !dxb[16] && (dxb != 17'd0);
    side_in.neg_zb    = !dzb[16] && (dzb != 17'd0);
  end

  // valid bits travel with the cells
  always_comb begin
    vld_nxt = vld_r;
    if (adv) vld_nxt = {vld_r[NSTG-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload shift, frozen together with the valid bits
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side_in;
      for (int i = 1; i < NSTG; i++) side_r[i] <= side_r[i-1];
      mag_r[0] <= mag_of(dxa);
      mag_r[1] <= mag_of(dza);
      mag_r[2] <= mag_of(dxb);
      mag_r[3] <= mag_of(dzb);
      for (int i = 0; i < 4; i++) begin
        sq_r[i]  <= MAG2_W'(mag_r[i]) * MAG2_W'(mag_r[i]);
        sq2_r[i] <= sq_r[i];
      end
      sum_a_r <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(ONE_SQ);
      sum_b_r <= SUM_W'(sq_r[2]) + SUM_W'(sq_r[3]) + SUM_W'(ONE_SQ);
    end
  end

  hqvn_norm_lane u_lane_xa (.clk, .en(adv), .mag2_i(sq2_r[0]), .sum_i(sum_a_r),
                            .mag_o(lane_mag[0]));
  hqvn_norm_lane u_lane_ya (.clk, .en(adv), .mag2_i(ONE_SQ),   .sum_i(sum_a_r),
                            .mag_o(lane_mag[1]));
  hqvn_norm_lane u_lane_za (.clk, .en(adv), .mag2_i(sq2_r[1]), .sum_i(sum_a_r),
                            .mag_o(lane_mag[2]));
  hqvn_norm_lane u_lane_xb (.clk, .en(adv), .mag2_i(sq2_r[2]), .sum_i(sum_b_r),
                            .mag_o(lane_mag[3]));
  hqvn_norm_lane u_lane_yb (.clk, .en(adv), .mag2_i(ONE_SQ),   .sum_i(sum_b_r),
                            .mag_o(lane_mag[4]));
  hqvn_norm_lane u_lane_zb (.clk, .en(adv), .mag2_i(sq2_r[3]), .sum_i(sum_b_r),
                            .mag_o(lane_mag[5]));

  // output register: one cell, four beats
  always_comb begin
    hold_vld_nxt = hold_vld_r;
    if (hold_free) hold_vld_nxt = vld_r[NSTG-1];
    // wraps back to zero after the last beat
    hold_k_nxt = beat_take ? (hold_k_r + 2'd1) : hold_k_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      hold_k_r   <= '0;
    end else begin
      hold_vld_r <= hold_vld_nxt;
      hold_k_r   <= hold_k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_free && vld_r[NSTG-1]) begin
      hold_side_r <= side_r[NSTG-1];
      hold_na_x_r <= signed_nrm(side_r[NSTG-1].neg_xa, lane_mag[0]);
      hold_na_y_r <= lane_mag[1];
      hold_na_z_r <= signed_nrm(side_r[NSTG-1].neg_za, lane_mag[2]);
      hold_nb_x_r <= signed_nrm(side_r[NSTG-1].neg_xb, lane_mag[3]);
      hold_nb_y_r <= lane_mag[4];
      hold_nb_z_r <= signed_nrm(side_r[NSTG-1].neg_zb, lane_mag[5]);
    end
  end

  // beat fields
  assign rgb               = colour_of(hold_side_r.band);
  assign out_valid         = hold_vld_r;
  assign out_vertex_number = {hold_side_r.vbase, hold_k_r};
  assign out_pos_x         = {1'b0, hold_side_r.cell_x} + {7'd0, hold_k_r[0]};
  assign out_pos_z         = {1'b0, hold_side_r.cell_z} + {7'd0, hold_k_r[1]};
  assign out_pos_height    = hold_side_r.height[hold_k_r];
  assign out_colour_red    = rgb.red;
  assign out_colour_green  = rgb.green;
  assign out_colour_blue   = rgb.blue;
  // the fourth vertex belongs to the second triangle
  assign out_normal_x      = is_last ? hold_nb_x_r : hold_na_x_r;
  assign out_normal_y      = is_last ? hold_nb_y_r : hold_na_y_r;
  assign out_normal_z      = is_last ? hold_nb_z_r : hold_na_z_r;
  assign out_last_vertex   = is_last;

  // a cell's beats come back to back with consecutive vertex numbers
  `HQVN_NEXT(a_cell_beats_run, beat_take && !is_last, out_valid && (out_vertex_number == $past(out_vertex_number) + 16'd1))
  // the input only stalls when both the last stage and the output register are full
  `HQVN_SAME(a_stall_only_full, in_stall, vld_r[NSTG-1] && hold_vld_r)
  // with nothing behind it the output goes idle after the last beat
  `HQVN_NEXT(a_drain_after_last, beat_take && is_last && !vld_r[NSTG-1], !out_valid)

endmodule

### tb/heightmap_quad_vertex_normals_unit_test.sv
// self-checking testbench for heightmap_quad_vertex_normals_unit
// depends on hqvn_pkg (chunk width) and the unit's rtl; needs no other file
`timescale 1ns / 100ps

module heightmap_quad_vertex_normals_unit_test;

  localparam int HOLD_CYCLES = 150;   // long receiver hold-off, fills the pipeline
  localparam int STUCK_LIMIT = 2000;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES = 40;   // wait after the drain for a stray late beat
  localparam int RANDOM_CELLS = 96;

  // one grid cell; corner k is h0, h1, h2, h3 in vertex order
  typedef struct packed {
    logic [6:0]       cx;
    logic [6:0]       cz;
    logic [3:0][15:0] h;
  } cell_t;

  typedef struct packed {
    logic signed [15:0] nx;
    logic [14:0]        ny;
    logic signed [15:0] nz;
  } normal_t;

  typedef struct packed {
    logic [15:0]        number;
    logic [7:0]         px;
    logic [7:0]         pz;
    logic [15:0]        height;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic signed [15:0] nx;
    logic [14:0]        ny;
    logic signed [15:0] nz;
    logic               last;
  } vertex_t;

  // works out the four vertices of each accepted cell and holds them in order
  class quad_vertex_tracker;
    vertex_t pending_vertices[$];
    int      errors;

    function new();
      errors = 0;
    endfunction

    // rounded mag*16384/sqrt(s), found as the largest m with (2m-1)^2*s <= 4*(mag*16384)^2,
    // which rounds exact halves away from zero
    function logic [14:0] q14_fraction(longint unsigned mag, longint unsigned s);
      longint unsigned t, rhs, lo, hi, mid, odd;
      t = mag * 64'd16384;
      rhs = 64'd4 * t * t;
      lo = 0;
      hi = 16384;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        odd = 2 * mid - 1;
        if (odd * odd * s <= rhs) lo = mid;
        else hi = mid - 1;
      end
      return lo[14:0];
    endfunction

    // unit normal of the raw vector (-dx, 256, -dz), heights in 1/256 units
    function normal_t unit_face_normal(int dx, int dz);
      longint unsigned ax, az, s;
      logic [15:0] mx, mz;
      normal_t n;
      ax = (dx < 0) ? -dx : dx;
      az = (dz < 0) ? -dz : dz;
      s = ax * ax + 64'd65536 + az * az;
      mx = {1'b0, q14_fraction(ax, s)};
      mz = {1'b0, q14_fraction(az, s)};
      n.nx = (dx > 0) ? -mx : mx;
      n.ny = q14_fraction(64'd256, s);
      n.nz = (dz > 0) ? -mz : mz;
      return n;
    endfunction

    // biome color from the first corner height, thresholds in whole height units
    function logic [23:0] biome_colour(logic [15:0] hgt);
      if (hgt < 16'd8 * 256) return 24'h0033CC;
      else if (hgt < 16'd16 * 256) return 24'h0080FF;
      else if (hgt < 16'd20 * 256) return 24'hFFFF80;
      else if (hgt < 16'd32 * 256) return 24'h33CC1A;
      else if (hgt < 16'd36 * 256) return 24'h33991A;
      else if (hgt < 16'd48 * 256) return 24'h33801A;
      else if (hgt < 16'd56 * 256) return 24'h4D4D1A;
      else if (hgt < 16'd72 * 256) return 24'h66331A;
      else if (hgt < 16'd88 * 256) return 24'h99664D;
      else if (hgt < 16'd96 * 256) return 24'hFFCCB3;
      else return 24'hFFFFFF;
    endfunction

    function void take_cell(cell_t c);
      normal_t     first_tri, second_tri, n;
      logic [23:0] rgb;
      int          base;
      vertex_t     v;
      first_tri = unit_face_normal(int'(c.h[1]) - int'(c.h[0]), int'(c.h[2]) - int'(c.h[0]));
      second_tri = unit_face_normal(int'(c.h[3]) - int'(c.h[2]), int'(c.h[3]) - int'(c.h[1]));
      rgb = biome_colour(c.h[0]);
      // cells outside the chunk are not rejected, their numbers can match other cells'
      base = (int'(c.cx) * hqvn_pkg::CHUNK_WIDTH + int'(c.cz)) * 4;
      for (int k = 0; k < 4; k++) begin
        n = (k == 3) ? second_tri : first_tri;
        v.number = 16'(base + k);
        v.px = {1'b0, c.cx} + 8'(k & 1);
        v.pz = {1'b0, c.cz} + 8'(k >> 1);
        v.height = c.h[k];
        {v.red, v.green, v.blue} = rgb;
        v.nx = n.nx;
        v.ny = n.ny;
        v.nz = n.nz;
        v.last = (k == 3);
        pending_vertices = {pending_vertices, v};
      end
    endfunction

    function void match_field(string field, int want, int seen);
      if (want != seen) begin
        $error("%s: expected %0d, got %0d", field, want, seen);
        errors++;
      end
    endfunction

    function void match_vertex(vertex_t got);
      vertex_t want;
      if (pending_vertices.size() == 0) begin
        $error("vertex beat %0d with no cell waiting for it", got.number);
        errors++;
        return;
      end
      want = pending_vertices.pop_front();
      match_field("vertex_number", want.number, got.number);
      match_field("pos_x", want.px, got.px);
      match_field("pos_z", want.pz, got.pz);
      match_field("pos_height", want.height, got.height);
      match_field("colour_red", want.red, got.red);
      match_field("colour_green", want.green, got.green);
      match_field("colour_blue", want.blue, got.blue);
      match_field("normal_x", int'(want.nx), int'(got.nx));
      match_field("normal_y", want.ny, got.ny);
      match_field("normal_z", int'(want.nz), int'(got.nz));
      match_field("last_vertex", want.last, got.last);
    endfunction

    function int pending();
      return pending_vertices.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [6:0]         in_cell_x = '0;
  logic [6:0]         in_cell_z = '0;
  logic [15:0]        in_height_here = '0;
  logic [15:0]        in_height_next_x = '0;
  logic [15:0]        in_height_next_z = '0;
  logic [15:0]        in_height_diagonal = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [15:0]        out_vertex_number;
  logic [7:0]         out_pos_x;
  logic [7:0]         out_pos_z;
  logic [15:0]        out_pos_height;
  logic [7:0]         out_colour_red;
  logic [7:0]         out_colour_green;
  logic [7:0]         out_colour_blue;
  logic signed [15:0] out_normal_x;
  logic [14:0]        out_normal_y;
  logic signed [15:0] out_normal_z;
  logic               out_last_vertex;

  quad_vertex_tracker tracker;
  int                 cells_in = 0;   // cells accepted so far
  int                 stuck_cycles = 0;
  bit                 held_off = 1'b0;
  int                 hold_left = 0;

  // the bench adds no gaps or stalls on either side through this window of cells
  wire calm = (cells_in >= 60) && (cells_in < 90);

  heightmap_quad_vertex_normals_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cell_x          (in_cell_x),
    .in_cell_z          (in_cell_z),
    .in_height_here     (in_height_here),
    .in_height_next_x   (in_height_next_x),
    .in_height_next_z   (in_height_next_z),
    .in_height_diagonal (in_height_diagonal),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_vertex_number  (out_vertex_number),
    .out_pos_x          (out_pos_x),
    .out_pos_z          (out_pos_z),
    .out_pos_height     (out_pos_height),
    .out_colour_red     (out_colour_red),
    .out_colour_green   (out_colour_green),
    .out_colour_blue    (out_colour_blue),
    .out_normal_x       (out_normal_x),
    .out_normal_y       (out_normal_y),
    .out_normal_z       (out_normal_z),
    .out_last_vertex    (out_last_vertex)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic cell_t make_cell(int cx, int cz, int h0, int h1, int h2, int h3);
    cell_t c;
    c.cx = 7'(cx);
    c.cz = 7'(cz);
    c.h[0] = 16'(h0);
    c.h[1] = 16'(h1);
    c.h[2] = 16'(h2);
    c.h[3] = 16'(h3);
    return c;
  endfunction

  // a height within spread of base, clamped to the Q8.8 range
  function automatic int near(int base, int spread);
    int v;
    v = base + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v;
  endfunction

  // offer one cell, sometimes after a short gap, and hold it until the block takes it
  task automatic offer_cell(input cell_t c);
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cell_x <= c.cx;
    in_cell_z <= c.cz;
    in_height_here <= c.h[0];
    in_height_next_x <= c.h[1];
    in_height_next_z <= c.h[2];
    in_height_diagonal <= c.h[3];
    do @(posedge clk); while (in_stall);
    tracker.take_cell(c);
    cells_in++;
  endtask

  // result side: random stall, one long hold-off once the stream is going,
  // then no stall at all inside the calm window
  initial begin
    forever begin
      @(negedge clk);
      if (!held_off && cells_in >= 30) begin
        held_off = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 13);
      end
    end
  end

  // vertex beats are checked in arrival order; the watchdog counts beatless cycles
  always @(posedge clk) begin
    vertex_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.number = out_vertex_number;
      got.px = out_pos_x;
      got.pz = out_pos_z;
      got.height = out_pos_height;
      got.red = out_colour_red;
      got.green = out_colour_green;
      got.blue = out_colour_blue;
      got.nx = out_normal_x;
      got.ny = out_normal_y;
      got.nz = out_normal_z;
      got.last = out_last_vertex;
      tracker.match_vertex(got);
    end
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("heightmap_quad_vertex_normals_unit_test: errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int    edges[10];
    int    h0, kind, spread;
    cell_t c;
    edges = '{8, 16, 20, 32, 36, 48, 56, 72, 88, 96};
    tracker = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // flat cell at zero: straight-up normal, lowest biome
    offer_cell(make_cell(0, 0, 0, 0, 0, 0));
    // each biome threshold from just below (sloped) and exactly on it (flat)
    for (int i = 0; i < 10; i++) begin
      h0 = edges[i] * 256 - 1;
      offer_cell(make_cell($urandom_range(0, 127), $urandom_range(0, 127), h0,
                           near(h0, 64), near(h0, 64), near(h0, 64)));
      h0 = edges[i] * 256;
      offer_cell(make_cell($urandom_range(0, 127), $urandom_range(0, 127), h0, h0, h0, h0));
    end
    // corner of the coordinate range, outside the chunk, top height
    offer_cell(make_cell(127, 127, 65535, 65535, 65535, 65535));
    // steepest slopes both ways, both triangles
    offer_cell(make_cell(0, 127, 0, 65535, 65535, 0));
    offer_cell(make_cell(127, 0, 65535, 0, 0, 65535));

    // mostly gentle terrain so normals spread out, plus noise, flats and cliffs
    for (int n = 0; n < RANDOM_CELLS; n++) begin
      kind = $urandom_range(0, 99);
      h0 = $urandom_range(0, 65535);
      if (kind < 55) begin
        case ($urandom_range(0, 2))
          0: spread = 16;
          1: spread = 256;
          default: spread = 2048;
        endcase
        c = make_cell($urandom_range(0, 127), $urandom_range(0, 127), h0,
                      near(h0, spread), near(h0, spread), near(h0, spread));
      end else if (kind < 80) begin
        c = make_cell($urandom_range(0, 127), $urandom_range(0, 127), h0,
                      $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535));
      end else if (kind < 90) begin
        c = make_cell($urandom_range(0, 127), $urandom_range(0, 127), h0, h0, h0, h0);
      end else begin
        c = make_cell($urandom_range(0, 127), $urandom_range(0, 127),
                      $urandom_range(0, 1) * 65535, $urandom_range(0, 1) * 65535,
                      $urandom_range(0, 1) * 65535, $urandom_range(0, 1) * 65535);
      end
      offer_cell(c);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then give a stray late beat time to show up
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("heightmap_quad_vertex_normals_unit_test: clean");
    end else begin
      $display("heightmap_quad_vertex_normals_unit_test: errors");
    end
    $finish;
  end

endmodule
